### sv/lrc_pkg.sv
// Package for the linear regression and correlation block: widths, step codes
// and arithmetic op codes shared by the top level. No dependencies.
package lrc_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // internal word of the shared arithmetic unit
  localparam int unsigned WORD_W = 128;

  // result field widths
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned SLOPE_W = 32;
  localparam int unsigned ICPT_W  = 32;
  localparam int unsigned CORR_W  = 16;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned OUT_FIELDS_W = 2 * MEAN_W + SLOPE_W + ICPT_W + CORR_W + 2 * CLASS_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [CLASS_W-1:0] class_t;

  localparam class_t STR_WEAK     = 2'd0;
  localparam class_t STR_MODERATE = 2'd1;
  localparam class_t STR_STRONG   = 2'd2;
  localparam class_t STR_UNDEF    = 2'd3;

  localparam class_t STAT_OK       = 2'd0;
  localparam class_t STAT_FEW      = 2'd1;
  localparam class_t STAT_X_CONST  = 2'd2;
  localparam class_t STAT_Y_CONST  = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SUB  = 2'd1,
    OP_RDIV = 2'd2,
    OP_SQRT = 2'd3
  } op_t;

  typedef logic [4:0] step_t;

  localparam step_t ST_MEAN_X   = 5'd0;
  localparam step_t ST_MEAN_Y   = 5'd1;
  localparam step_t ST_NSXX     = 5'd2;
  localparam step_t ST_SXSX     = 5'd3;
  localparam step_t ST_DXX      = 5'd4;
  localparam step_t ST_NSYY     = 5'd5;
  localparam step_t ST_SYSY     = 5'd6;
  localparam step_t ST_DYY      = 5'd7;
  localparam step_t ST_NSXY     = 5'd8;
  localparam step_t ST_SXSY     = 5'd9;
  localparam step_t ST_DXY      = 5'd10;
  localparam step_t ST_SYDXX    = 5'd11;
  localparam step_t ST_SXDXY    = 5'd12;
  localparam step_t ST_INUM     = 5'd13;
  localparam step_t ST_NDXX     = 5'd14;
  localparam step_t ST_SLOPE    = 5'd15;
  localparam step_t ST_ICPT     = 5'd16;
  localparam step_t ST_PROD     = 5'd17;
  localparam step_t ST_DXY2     = 5'd18;
  localparam step_t ST_ROOT     = 5'd19;
  localparam step_t ST_CORR     = 5'd20;
  localparam step_t ST_WEAK     = 5'd21;
  localparam step_t ST_D2X25    = 5'd22;
  localparam step_t ST_MODERATE = 5'd23;

endpackage

### sv/linear_regression_correlation.sv
// Top level of the linear regression and correlation block: accumulators,
// sequencer and the shared 128-bit multiply / divide / square-root unit.
// Depends on lrc_pkg.
//
// Paired (x, y) samples arrive one request per cycle on the slave stream while
// s_tready is high, x in the low half of s_tdata, and are folded into running
// sums of x, y, x*x, y*y, x*y and a count; samples after MAX_SAMPLES are dropped
// from the sums. A pair with s_tlast closes the data set: the block then drops
// s_tready and a sequencer walks up to 24 steps through one shared 128-bit unit,
// each step passing through a load state, its operation and a write-back state.
// A multiply is shift-add, one multiplier bit a cycle, stopping early when the
// remaining multiplier bits are zero, so it runs longest when the multiplier is
// negative; a rounded divide takes the absolute value of the dividend, adds the
// rounding term, runs a restoring division and restores the sign; the square
// root alternates an add and a compare-subtract state for each result bit. The
// time to a result thus depends on the signs and sizes of the multiplier
// operands; a set of fewer than two samples stops after the means. The result
// (means, slope, intercept, Pearson r, strength class and status) is held in an
// output register on the master stream, so the next data set may start while it
// waits to be taken.
module linear_regression_correlation #(
  parameter int unsigned MAX_SAMPLES  = lrc_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_WIDTH = lrc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // fields from bit 0: x_value, y_value, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // fields from bit 0: mean_x, mean_y, slope, intercept, correlation,
  // strength, status, zero fill
  output logic [lrc_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned W      = lrc_pkg::WORD_W;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = SAMPLE_WIDTH + $clog2(MAX_SAMPLES) + 1;
  localparam int unsigned SQ_W   = 2 * SAMPLE_WIDTH + $clog2(MAX_SAMPLES) - 1;
  localparam int unsigned XY_W   = 2 * SAMPLE_WIDTH + $clog2(MAX_SAMPLES);
  localparam int unsigned IT_W   = $clog2(W);
  localparam int unsigned MW     = lrc_pkg::MEAN_W;
  localparam int unsigned SW32   = lrc_pkg::SLOPE_W;
  localparam int unsigned CW     = lrc_pkg::CORR_W;
  localparam int unsigned PAD_W  = lrc_pkg::OUT_DATA_W - lrc_pkg::OUT_FIELDS_W;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_LOAD    = 11'b000_0000_0010,
    S_MUL     = 11'b000_0000_0100,
    S_SUB     = 11'b000_0000_1000,
    S_RD_ABS  = 11'b000_0001_0000,
    S_RD_PREP = 11'b000_0010_0000,
    S_DIV     = 11'b000_0100_0000,
    S_RD_FIX  = 11'b000_1000_0000,
    S_SQ_ADD  = 11'b001_0000_0000,
    S_SQ_SUB  = 11'b010_0000_0000,
    S_WRITE   = 11'b100_0000_0000
  } state_t;

  state_t state;

  // accumulators; sums of squares never go negative and may reach 2^(SQ_W-1)
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [SQ_W-1:0]         sum_xx, sum_yy;
  logic signed [XY_W-1:0]  sum_xy;
  logic [CNT_W-1:0]        sample_count;

  // shared unit
  lrc_pkg::step_t step;
  lrc_pkg::op_t   op_sel;
  logic [W-1:0]   sel_a, sel_b;
  logic [W-1:0]   op_a, op_b, acc, aux, rem;
  logic [W:0]     rem_try;
  logic [IT_W-1:0] iter;
  logic            neg, borrow;

  // intermediate values
  logic [W-1:0] dxx, dyy, dxy, t1, t2, inum, nd, prod, d2;
  logic         weak_fail;

  // result fields
  logic [MW-1:0]   res_mx, res_my;
  logic [SW32-1:0] res_sl, res_ic;
  logic [CW-1:0]   res_co;
  lrc_pkg::class_t res_st, res_ss;
  logic            res_pend;

  logic signed [SAMPLE_WIDTH-1:0] x_in, y_in;
  logic [W-1:0] w_n, w_sx, w_sy, w_sxx, w_syy, w_sxy;
  logic fits_mean, fits_32, fits_corr;
  logic out_free;

  assign x_in = s_tdata[SAMPLE_WIDTH-1:0];
  assign y_in = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  assign w_n   = {{(W-CNT_W){1'b0}}, sample_count};
  assign w_sx  = {{(W-SUM_W){sum_x[SUM_W-1]}}, sum_x};
  assign w_sy  = {{(W-SUM_W){sum_y[SUM_W-1]}}, sum_y};
  assign w_sxx = {{(W-SQ_W){1'b0}}, sum_xx};
  assign w_syy = {{(W-SQ_W){1'b0}}, sum_yy};
  assign w_sxy = {{(W-XY_W){sum_xy[XY_W-1]}}, sum_xy};

  assign s_tready = (state == S_IDLE) && !res_pend;
  assign out_free = !m_tvalid || m_tready;

  // operands and op for each step; fixed power-of-two scalings are shifts
  always_comb begin
    op_sel = lrc_pkg::OP_MUL;
    sel_a  = '0;
    sel_b  = '0;
    case (step)
      lrc_pkg::ST_MEAN_X:   begin op_sel = lrc_pkg::OP_RDIV; sel_a = w_sx << 8;  sel_b = w_n; end
      lrc_pkg::ST_MEAN_Y:   begin op_sel = lrc_pkg::OP_RDIV; sel_a = w_sy << 8;  sel_b = w_n; end
      lrc_pkg::ST_NSXX:     begin sel_a = w_n;  sel_b = w_sxx; end
      lrc_pkg::ST_SXSX:     begin sel_a = w_sx; sel_b = w_sx;  end
      lrc_pkg::ST_DXX:      begin op_sel = lrc_pkg::OP_SUB; sel_a = t1; sel_b = t2; end
      lrc_pkg::ST_NSYY:     begin sel_a = w_n;  sel_b = w_syy; end
      lrc_pkg::ST_SYSY:     begin sel_a = w_sy; sel_b = w_sy;  end
      lrc_pkg::ST_DYY:      begin op_sel = lrc_pkg::OP_SUB; sel_a = t1; sel_b = t2; end
      lrc_pkg::ST_NSXY:     begin sel_a = w_n;  sel_b = w_sxy; end
      lrc_pkg::ST_SXSY:     begin sel_a = w_sx; sel_b = w_sy;  end
      lrc_pkg::ST_DXY:      begin op_sel = lrc_pkg::OP_SUB; sel_a = t1; sel_b = t2; end
      lrc_pkg::ST_SYDXX:    begin sel_a = w_sy; sel_b = dxx; end
      lrc_pkg::ST_SXDXY:    begin sel_a = w_sx; sel_b = dxy; end
      lrc_pkg::ST_INUM:     begin op_sel = lrc_pkg::OP_SUB; sel_a = t1; sel_b = t2; end
      lrc_pkg::ST_NDXX:     begin sel_a = w_n;  sel_b = dxx; end
      lrc_pkg::ST_SLOPE:    begin op_sel = lrc_pkg::OP_RDIV; sel_a = dxy << 16;  sel_b = dxx; end
      lrc_pkg::ST_ICPT:     begin op_sel = lrc_pkg::OP_RDIV; sel_a = inum << 16; sel_b = nd; end
      lrc_pkg::ST_PROD:     begin sel_a = dxx;  sel_b = dyy; end
      lrc_pkg::ST_DXY2:     begin sel_a = dxy;  sel_b = dxy; end
      lrc_pkg::ST_ROOT:     begin
        op_sel = lrc_pkg::OP_SQRT;
        sel_a  = prod;
        sel_b  = {2'b01, {(W-2){1'b0}}};
      end
      lrc_pkg::ST_CORR:     begin op_sel = lrc_pkg::OP_RDIV; sel_a = dxy << 15;  sel_b = t1; end
      lrc_pkg::ST_WEAK:     begin op_sel = lrc_pkg::OP_SUB; sel_a = prod; sel_b = d2 << 2; end
      lrc_pkg::ST_D2X25:    begin sel_a = d2; sel_b = W'(25); end
      lrc_pkg::ST_MODERATE: begin op_sel = lrc_pkg::OP_SUB; sel_a = prod << 4; sel_b = t2; end
      default:              begin sel_a = '0; sel_b = '0; end
    endcase
  end

  assign rem_try = {rem, op_a[W-1]};

  // saturation: the result fits when all bits above its sign bit repeat it
  assign fits_mean = (&acc[W-1:MW-1])   || !(|acc[W-1:MW-1]);
  assign fits_32   = (&acc[W-1:SW32-1]) || !(|acc[W-1:SW32-1]);
  assign fits_corr = (&acc[W-1:CW-1])   || !(|acc[W-1:CW-1]);

  // accumulators: fold one pair per request up to MAX_SAMPLES, clear once the result is handed over
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0; sum_y <= '0; sum_xx <= '0; sum_yy <= '0; sum_xy <= '0;
      sample_count <= '0;
    end else if (s_tvalid && s_tready) begin
      if (sample_count < CNT_W'(MAX_SAMPLES)) begin
        sum_x  <= sum_x + SUM_W'(x_in);
        sum_y  <= sum_y + SUM_W'(y_in);
        sum_xx <= sum_xx + SQ_W'(x_in * x_in);
        sum_yy <= sum_yy + SQ_W'(y_in * y_in);
        sum_xy <= sum_xy + XY_W'(x_in * y_in);
        sample_count <= sample_count + 1'b1;
      end
    end else if (res_pend && out_free) begin
      sum_x <= '0; sum_y <= '0; sum_xx <= '0; sum_yy <= '0; sum_xy <= '0;
      sample_count <= '0;
    end
  end

  // sequencer and shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= lrc_pkg::ST_MEAN_X;
      res_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready && s_tlast) begin
            step   <= lrc_pkg::ST_MEAN_X;
            res_sl <= '0;
            res_ic <= '0;
            res_co <= '0;
            res_st <= lrc_pkg::STR_UNDEF;
            res_ss <= lrc_pkg::STAT_OK;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          op_a <= sel_a;
          op_b <= sel_b;
          acc  <= '0;
          case (op_sel)
            lrc_pkg::OP_MUL:  state <= S_MUL;
            lrc_pkg::OP_SUB:  state <= S_SUB;
            lrc_pkg::OP_RDIV: state <= S_RD_ABS;
            lrc_pkg::OP_SQRT: state <= S_SQ_ADD;
            default:          state <= S_MUL;
          endcase
        end
        S_MUL: begin
          // op_a is the multiplicand, op_b the remaining multiplier bits
          if (op_b == '0) begin
            state <= S_WRITE;
          end else begin
            if (op_b[0]) acc <= acc + op_a;
            op_a <= op_a << 1;
            op_b <= op_b >> 1;
          end
        end
        S_SUB: begin
          acc    <= op_a - op_b;
          borrow <= op_a < op_b;
          state  <= S_WRITE;
        end
        S_RD_ABS: begin
          neg  <= op_a[W-1];
          op_a <= op_a[W-1] ? -op_a : op_a;
          state <= S_RD_PREP;
        end
        S_RD_PREP: begin
          // round to nearest: (2|num| + den) / (2 den)
          op_a  <= (op_a << 1) + op_b;
          op_b  <= op_b << 1;
          rem   <= '0;
          iter  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring division; quotient bits shift in behind the dividend
          if (rem_try >= {1'b0, op_b}) begin
            rem  <= W'(rem_try - {1'b0, op_b});
            op_a <= {op_a[W-2:0], 1'b1};
          end else begin
            rem  <= rem_try[W-1:0];
            op_a <= {op_a[W-2:0], 1'b0};
          end
          iter <= iter + 1'b1;
          if (iter == IT_W'(W - 1)) state <= S_RD_FIX;
        end
        S_RD_FIX: begin
          acc   <= neg ? -op_a : op_a;
          state <= S_WRITE;
        end
        S_SQ_ADD: begin
          aux   <= acc + op_b;
          state <= S_SQ_SUB;
        end
        S_SQ_SUB: begin
          // op_a holds the remainder, op_b the trial bit, acc the root
          if (op_a >= aux) begin
            op_a <= op_a - aux;
            acc  <= (acc >> 1) + op_b;
          end else begin
            acc  <= acc >> 1;
          end
          op_b  <= op_b >> 2;
          state <= op_b[0] ? S_WRITE : S_SQ_ADD;
        end
        S_WRITE: begin
          state <= S_LOAD;
          step  <= step + 1'b1;
          case (step)
            lrc_pkg::ST_MEAN_X: res_mx <= fits_mean ? acc[MW-1:0] :
                                  {acc[W-1], {(MW-1){!acc[W-1]}}};
            lrc_pkg::ST_MEAN_Y: begin
              res_my <= fits_mean ? acc[MW-1:0] : {acc[W-1], {(MW-1){!acc[W-1]}}};
              if (sample_count < CNT_W'(2)) begin
                res_ss   <= lrc_pkg::STAT_FEW;
                res_pend <= 1'b1;
                state    <= S_IDLE;
              end
            end
            lrc_pkg::ST_NSXX, lrc_pkg::ST_NSYY, lrc_pkg::ST_NSXY,
            lrc_pkg::ST_SYDXX, lrc_pkg::ST_ROOT: t1 <= acc;
            lrc_pkg::ST_SXSX, lrc_pkg::ST_SYSY, lrc_pkg::ST_SXSY,
            lrc_pkg::ST_SXDXY, lrc_pkg::ST_D2X25: t2 <= acc;
            lrc_pkg::ST_DXX:  dxx <= acc;
            lrc_pkg::ST_DYY:  dyy <= acc;
            lrc_pkg::ST_DXY: begin
              dxy <= acc;
              if (dxx == '0) begin
                res_ss   <= lrc_pkg::STAT_X_CONST;
                res_pend <= 1'b1;
                state    <= S_IDLE;
              end
            end
            lrc_pkg::ST_INUM: inum <= acc;
            lrc_pkg::ST_NDXX: nd   <= acc;
            lrc_pkg::ST_SLOPE: res_sl <= fits_32 ? acc[SW32-1:0] :
                                 {acc[W-1], {(SW32-1){!acc[W-1]}}};
            lrc_pkg::ST_ICPT: begin
              res_ic <= fits_32 ? acc[SW32-1:0] : {acc[W-1], {(SW32-1){!acc[W-1]}}};
              if (dyy == '0) begin
                res_ss   <= lrc_pkg::STAT_Y_CONST;
                res_pend <= 1'b1;
                state    <= S_IDLE;
              end
            end
            lrc_pkg::ST_PROD: prod <= acc;
            lrc_pkg::ST_DXY2: d2   <= acc;
            lrc_pkg::ST_CORR: res_co <= fits_corr ? acc[CW-1:0] :
                                {acc[W-1], {(CW-1){!acc[W-1]}}};
            lrc_pkg::ST_WEAK: weak_fail <= borrow;
            lrc_pkg::ST_MODERATE: begin
              if (!weak_fail)   res_st <= lrc_pkg::STR_WEAK;
              else if (!borrow) res_st <= lrc_pkg::STR_MODERATE;
              else              res_st <= lrc_pkg::STR_STRONG;
              res_pend <= 1'b1;
              state    <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
      // hand the finished result to the output register once it is free
      if (res_pend && out_free) res_pend <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_pend && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {{PAD_W{1'b0}}, res_ss, res_st, res_co, res_ic, res_sl, res_my, res_mx};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
